// ===== src/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// Disk request scheduler package
// Shared types and constants: policy and status codes, queue entry layout,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int TRACK_LSB = 9;
    localparam int ADDR_W    = 32;
    localparam int TRACK_W   = ADDR_W - TRACK_LSB;
    localparam int TAG_W     = 8;
    localparam int PRI_W     = 8;
    localparam int PEND_W    = 5;

    typedef enum logic [1:0] {
        POL_FCFS     = 2'd0,
        POL_PRIORITY = 2'd1,
        POL_SSTF     = 2'd2,
        POL_SCAN     = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED   = 2'd0,
        ST_DISPATCHED = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    localparam logic CMD_ENQUEUE  = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] addr;
        logic [PRI_W-1:0]  pri;
        logic              disk;
    } entry_t;

    typedef struct packed {
        logic    load;
        logic    scan_issue;
        logic    pick;
        logic    fetch;
        logic    shift_issue;
        logic    finish;
        status_t code;
    } drs_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic scan_last;
        logic shift_more;
    } drs_stat_t;

endpackage

// ===== src/disk_request_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Disk request scheduler
// Arrival-ordered request queue with first-come, priority, shortest-seek and
// scan-elevator dispatch.
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ---------------------------------------
//  item in   start & !busy           cmd, request_tag, is_disk, byte_address,
//                                    req_priority, head_track
//  result    done (one cycle)        status, out_tag, out_address,
//                                    out_is_disk, pending, moving_up
//  config    cfg_valid & cfg_ready   cfg_data (policy)
//
// Enqueue, full and empty items: result in the cycle after acceptance, busy
// stays low. A dispatch holds busy through the steps that the single RAM read
// port serializes: a search over the queued entries, drain, pick, fetch,
// compaction of the entries behind the removed one, then the result.
// Reset empties the queue, selects first-come and points the scan upward;
// no clearing pass. Results cannot be stalled; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module disk_request_scheduler_top
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cmd,
    input  logic [TAG_W-1:0]    request_tag,
    input  logic                is_disk,
    input  logic [ADDR_W-1:0]   byte_address,
    input  logic [PRI_W-1:0]    req_priority,
    input  logic [TRACK_W-1:0]  head_track,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data,
    output logic                done,
    output logic [1:0]          status,
    output logic [TAG_W-1:0]    out_tag,
    output logic [ADDR_W-1:0]   out_address,
    output logic                out_is_disk,
    output logic [PEND_W-1:0]   pending,
    output logic                moving_up
);

    drs_ctl_t  ctl;
    drs_stat_t stat;

    assign cfg_ready = !busy;

    drs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    drs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .request_tag  (request_tag),
        .is_disk      (is_disk),
        .byte_address (byte_address),
        .req_priority (req_priority),
        .head_track   (head_track),
        .status       (status),
        .out_tag      (out_tag),
        .out_address  (out_address),
        .out_is_disk  (out_is_disk),
        .pending      (pending),
        .moving_up    (moving_up)
    );

endmodule

// ===== src/drs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module drs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/drs_dp.sv =====
// ----------------------------------------------------------------------------
// Disk request scheduler datapath
// Queue storage, candidate search over the entries, removal by compaction,
// policy register and result registers.
// ----------------------------------------------------------------------------
module drs_dp
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  drs_ctl_t            ctl,
    output drs_stat_t           stat,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_data,
    input  logic [TAG_W-1:0]    request_tag,
    input  logic                is_disk,
    input  logic [ADDR_W-1:0]   byte_address,
    input  logic [PRI_W-1:0]    req_priority,
    input  logic [TRACK_W-1:0]  head_track,
    output logic [1:0]          status,
    output logic [TAG_W-1:0]    out_tag,
    output logic [ADDR_W-1:0]   out_address,
    output logic                out_is_disk,
    output logic [PEND_W-1:0]   pending,
    output logic                moving_up
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = $bits(entry_t);

    // control state
    logic [CW-1:0]      count_reg, count_next;
    logic               scan_up_reg;
    policy_t            policy_reg;
    logic               eval_valid_reg;
    logic               wr_valid_reg;
    logic               any_found_reg, up_found_reg, dn_found_reg;

    // payload
    logic [TRACK_W-1:0] head_reg;
    logic [AW-1:0]      rd_idx_reg, eval_idx_reg;
    logic [AW-1:0]      any_idx_reg, up_idx_reg, dn_idx_reg, pri_idx_reg;
    logic [TRACK_W-1:0] any_d_reg, up_d_reg, dn_d_reg;
    logic [PRI_W-1:0]   best_pri_reg;
    logic [AW-1:0]      sel_reg;
    logic [CW-1:0]      sh_idx_reg;
    logic [AW-1:0]      wr_addr_reg;
    entry_t             hold_reg;
    status_t            result_code_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [ADDR_W-1:0]  out_address_reg;
    logic               out_is_disk_reg;
    logic [PEND_W-1:0]  pending_reg;
    logic               moving_up_reg;

    logic               enq_we;
    logic               ram_we;
    logic [AW-1:0]      ram_wr_addr;
    entry_t             ram_wr_data;
    logic [AW-1:0]      ram_rd_addr;
    logic [EW-1:0]      ram_rd_data;
    entry_t             rd_entry;

    logic [TRACK_W-1:0] track;
    logic               is_up, is_dn;
    logic [TRACK_W-1:0] seek_len;
    logic [AW-1:0]      sel_next;
    logic               flip;
    logic [CW+PEND_W-1:0] pend_ext;

    assign enq_we      = ctl.finish && (ctl.code == ST_ENQUEUED);
    assign ram_we      = enq_we || wr_valid_reg;
    assign ram_wr_addr = enq_we ? count_reg[AW-1:0] : wr_addr_reg;

    always_comb
    begin
        if (enq_we)
        begin
            ram_wr_data.tag  = request_tag;
            ram_wr_data.addr = byte_address;
            ram_wr_data.pri  = req_priority;
            ram_wr_data.disk = is_disk;
        end
        else
        begin
            ram_wr_data = rd_entry;
        end
    end

    always_comb
    begin
        if (ctl.pick)
        begin
            ram_rd_addr = sel_next;
        end
        else if (ctl.shift_issue)
        begin
            ram_rd_addr = sh_idx_reg[AW-1:0];
        end
        else
        begin
            ram_rd_addr = rd_idx_reg;
        end
    end

    drs_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_entry = entry_t'(ram_rd_data);

    // distance of the entry under evaluation from the head
    assign track    = rd_entry.addr[ADDR_W-1:TRACK_LSB];
    assign is_up    = (track >= head_reg);
    assign is_dn    = (track <= head_reg);
    assign seek_len = is_up ? (track - head_reg) : (head_reg - track);

    // choose the entry to remove; scan flips when nothing lies ahead
    always_comb
    begin
        sel_next = '0;
        flip     = 1'b0;
        unique case (policy_reg)
            POL_FCFS:
            begin
                sel_next = '0;
            end
            POL_PRIORITY:
            begin
                sel_next = pri_idx_reg;
            end
            POL_SSTF:
            begin
                sel_next = any_found_reg ? any_idx_reg : '0;
            end
            POL_SCAN:
            begin
                if (!any_found_reg)
                begin
                    sel_next = '0;
                end
                else if (scan_up_reg)
                begin
                    sel_next = up_found_reg ? up_idx_reg : dn_idx_reg;
                    flip     = !up_found_reg;
                end
                else
                begin
                    sel_next = dn_found_reg ? dn_idx_reg : up_idx_reg;
                    flip     = !dn_found_reg;
                end
            end
            default:
            begin
                sel_next = '0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.finish && (ctl.code == ST_ENQUEUED))
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.finish && (ctl.code == ST_DISPATCHED))
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign pend_ext = {{PEND_W{1'b0}}, count_next};

    assign stat.full       = (count_reg == CW'(QUEUE_DEPTH));
    assign stat.empty      = (count_reg == '0);
    assign stat.scan_last  = (CW'(rd_idx_reg) == (count_reg - CW'(1)));
    assign stat.shift_more = (sh_idx_reg < count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            scan_up_reg    <= 1'b1;
            policy_reg     <= POL_FCFS;
            eval_valid_reg <= 1'b0;
            wr_valid_reg   <= 1'b0;
            any_found_reg  <= 1'b0;
            up_found_reg   <= 1'b0;
            dn_found_reg   <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            eval_valid_reg <= ctl.scan_issue;
            wr_valid_reg   <= ctl.shift_issue;
            if (cfg_we)
            begin
                policy_reg <= policy_t'(cfg_data);
            end
            if (ctl.pick && flip)
            begin
                scan_up_reg <= !scan_up_reg;
            end
            if (ctl.load)
            begin
                any_found_reg <= 1'b0;
                up_found_reg  <= 1'b0;
                dn_found_reg  <= 1'b0;
            end
            else if (eval_valid_reg && rd_entry.disk)
            begin
                if (!any_found_reg || (seek_len < any_d_reg))
                begin
                    any_found_reg <= 1'b1;
                end
                if (is_up && (!up_found_reg || (seek_len < up_d_reg)))
                begin
                    up_found_reg <= 1'b1;
                end
                if (is_dn && (!dn_found_reg || (seek_len < dn_d_reg)))
                begin
                    dn_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            head_reg   <= head_track;
            rd_idx_reg <= '0;
        end
        else if (ctl.scan_issue)
        begin
            rd_idx_reg <= rd_idx_reg + AW'(1);
        end
        eval_idx_reg <= rd_idx_reg;

        if (eval_valid_reg)
        begin
            if ((eval_idx_reg == '0) || (rd_entry.pri > best_pri_reg))
            begin
                pri_idx_reg  <= eval_idx_reg;
                best_pri_reg <= rd_entry.pri;
            end
            if (rd_entry.disk)
            begin
                if (!any_found_reg || (seek_len < any_d_reg))
                begin
                    any_idx_reg <= eval_idx_reg;
                    any_d_reg   <= seek_len;
                end
                if (is_up && (!up_found_reg || (seek_len < up_d_reg)))
                begin
                    up_idx_reg <= eval_idx_reg;
                    up_d_reg   <= seek_len;
                end
                if (is_dn && (!dn_found_reg || (seek_len < dn_d_reg)))
                begin
                    dn_idx_reg <= eval_idx_reg;
                    dn_d_reg   <= seek_len;
                end
            end
        end

        if (ctl.pick)
        begin
            sel_reg <= sel_next;
        end

        // later entries move up one place: read i+1, write i in the next cycle
        if (ctl.fetch)
        begin
            hold_reg   <= rd_entry;
            sh_idx_reg <= CW'(sel_reg) + CW'(1);
        end
        else if (ctl.shift_issue)
        begin
            sh_idx_reg  <= sh_idx_reg + CW'(1);
            wr_addr_reg <= sh_idx_reg[AW-1:0] - AW'(1);
        end

        if (ctl.finish)
        begin
            result_code_reg <= ctl.code;
            pending_reg     <= pend_ext[PEND_W-1:0];
            moving_up_reg   <= scan_up_reg;
            if (ctl.code == ST_DISPATCHED)
            begin
                out_tag_reg     <= hold_reg.tag;
                out_address_reg <= hold_reg.addr;
                out_is_disk_reg <= hold_reg.disk;
            end
            else
            begin
                out_tag_reg     <= '0;
                out_address_reg <= '0;
                out_is_disk_reg <= 1'b0;
            end
        end
    end

    assign status      = result_code_reg;
    assign out_tag     = out_tag_reg;
    assign out_address = out_address_reg;
    assign out_is_disk = out_is_disk_reg;
    assign pending     = pending_reg;
    assign moving_up   = moving_up_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pick_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pick |-> !eval_valid_reg)
        else $error("pick while an entry is still under evaluation");

    a_write_port: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> !enq_we)
        else $error("enqueue write collides with compaction write");

    a_side_found: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pick |-> (!any_found_reg || up_found_reg || dn_found_reg))
        else $error("disk entry found but on neither side of the head");

    a_dispatch_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish && (ctl.code == ST_DISPATCHED)) |=>
            ((count_reg + CW'(1)) == $past(count_reg)))
        else $error("dispatch did not remove exactly one entry");

endmodule

// ===== src/drs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Disk request scheduler controller
// Sequences enqueue, search, selection, compaction and result strobe.
// ----------------------------------------------------------------------------
module drs_ctrl
    import drs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      cmd,
    input  drs_stat_t stat,
    output drs_ctl_t  ctl,
    output logic      busy,
    output logic      done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_FETCH,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.code   = ST_ENQUEUED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_ENQUEUE)
                    begin
                        ctl.finish = 1'b1;
                        ctl.code   = stat.full ? ST_FULL : ST_ENQUEUED;
                    end
                    else if (stat.empty)
                    begin
                        ctl.finish = 1'b1;
                        ctl.code   = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.load   = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                ctl.scan_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                ctl.pick   = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                ctl.fetch  = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                ctl.shift_issue = stat.shift_more;
                if (!stat.shift_more)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                ctl.finish = 1'b1;
                ctl.code   = ST_DISPATCHED;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctl.finish;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== dv/disk_request_scheduler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk request scheduler checker
// Watches the item, config and result channels. Keeps its own copy of the
// request queue, policy and scan direction, predicts the result of every
// accepted item and compares results field by field against the oldest one.
// ----------------------------------------------------------------------------
module disk_request_scheduler_checker
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                cmd,
    input  logic [TAG_W-1:0]    request_tag,
    input  logic                is_disk,
    input  logic [ADDR_W-1:0]   byte_address,
    input  logic [PRI_W-1:0]    req_priority,
    input  logic [TRACK_W-1:0]  head_track,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_data,
    input  logic                done,
    input  logic [1:0]          status,
    input  logic [TAG_W-1:0]    out_tag,
    input  logic [ADDR_W-1:0]   out_address,
    input  logic                out_is_disk,
    input  logic [PEND_W-1:0]   pending,
    input  logic                moving_up,
    output int                  failures,
    output int                  outstanding
);

    typedef enum int {
        SEEK_ANY,
        SEEK_UP,
        SEEK_DOWN
    } seek_dir_e;

    typedef struct packed {
        status_t           st;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] addr;
        logic              disk;
        logic [PEND_W-1:0] pend;
        logic              up;
    } sched_result_t;

    policy_t       cur_policy = POL_FCFS;
    entry_t        slot [QUEUE_DEPTH];
    int            queued     = 0;
    logic          scan_up    = 1'b1;
    sched_result_t owed [$];
    int            fail_count = 0;

    assign failures = fail_count;

    // Oldest disk entry nearest the head, optionally on one side only; -1 if none.
    function automatic int nearest_disk(input logic [TRACK_W-1:0] head, input seek_dir_e dir);
        int                 best;
        logic [TRACK_W-1:0] best_len;
        logic [TRACK_W-1:0] trk;
        logic [TRACK_W-1:0] seek_len;
        best     = -1;
        best_len = '0;
        for (int i = 0; i < queued; i++)
        begin
            trk = slot[i].addr[ADDR_W-1:TRACK_LSB];
            if (slot[i].disk && !(dir == SEEK_UP && trk < head)
                    && !(dir == SEEK_DOWN && trk > head))
            begin
                seek_len = (trk > head) ? trk - head : head - trk;
                if (best < 0 || seek_len < best_len)
                begin
                    best     = i;
                    best_len = seek_len;
                end
            end
        end
        return best;
    endfunction

    function automatic int pick_slot(input logic [TRACK_W-1:0] head);
        int sel;
        sel = 0;
        case (cur_policy)
            POL_PRIORITY:
                for (int i = 1; i < queued; i++)
                    if (slot[i].pri > slot[sel].pri)
                        sel = i;
            POL_SSTF:
            begin
                sel = nearest_disk(head, SEEK_ANY);
                if (sel < 0)
                    sel = 0;
            end
            POL_SCAN:
                // no disk entry at all: oldest entry, direction held
                if (nearest_disk(head, SEEK_ANY) >= 0)
                begin
                    sel = nearest_disk(head, scan_up ? SEEK_UP : SEEK_DOWN);
                    if (sel < 0)
                    begin
                        scan_up = !scan_up;
                        sel     = nearest_disk(head, scan_up ? SEEK_UP : SEEK_DOWN);
                        if (sel < 0)
                            sel = 0;
                    end
                end
            default:
                sel = 0;
        endcase
        return sel;
    endfunction

    task automatic schedule_step(output sched_result_t res);
        int sel;
        res = '0;
        if (cmd == CMD_ENQUEUE)
        begin
            if (queued >= QUEUE_DEPTH)
                res.st = ST_FULL;
            else
            begin
                slot[queued] = '{tag: request_tag, addr: byte_address, pri: req_priority,
                                 disk: is_disk};
                queued++;
                res.st = ST_ENQUEUED;
            end
        end
        else if (queued == 0)
            res.st = ST_EMPTY;
        else
        begin
            sel      = pick_slot(head_track);
            res.st   = ST_DISPATCHED;
            res.tag  = slot[sel].tag;
            res.addr = slot[sel].addr;
            res.disk = slot[sel].disk;
            // close the gap, keeping arrival order
            for (int i = sel; i + 1 < queued; i++)
                slot[i] = slot[i + 1];
            queued--;
        end
        res.pend = PEND_W'(queued);
        res.up   = scan_up;
    endtask

    function automatic void check_field(input string name, input logic [ADDR_W-1:0] want,
                                        input logic [ADDR_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 40)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            cur_policy = POL_FCFS;
            queued     = 0;
            scan_up    = 1'b1;
            owed.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (owed.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 40)
                        $display("%0t: unexpected result, expected none, got status %0d tag %0h",
                                 $time, status, out_tag);
                end
                else
                begin
                    want = owed.pop_front();
                    check_field("status", ADDR_W'(want.st), ADDR_W'(status));
                    check_field("out_tag", ADDR_W'(want.tag), ADDR_W'(out_tag));
                    check_field("out_address", want.addr, out_address);
                    check_field("out_is_disk", ADDR_W'(want.disk), ADDR_W'(out_is_disk));
                    check_field("pending", ADDR_W'(want.pend), ADDR_W'(pending));
                    check_field("moving_up", ADDR_W'(want.up), ADDR_W'(moving_up));
                end
            end
            if (cfg_valid && cfg_ready)
                cur_policy = policy_t'(cfg_data);
            if (start && !busy)
            begin
                schedule_step(want);
                owed.push_back(want);
            end
            outstanding <= owed.size();
        end
    end

endmodule

// ===== dv/disk_request_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk request scheduler testbench
// Drives enqueue and dispatch items under every policy: a directed fill to
// full with field extremes and scan turnarounds, then random phases with
// clustered tracks and bursty idle gaps. The checker does the comparing.
// ----------------------------------------------------------------------------
module disk_request_scheduler_top_tb;
    import drs_pkg::*;

    localparam int DEPTH         = 16;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 40;
    localparam int BAND          = 47;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic               cmd          = CMD_ENQUEUE;
    logic [TAG_W-1:0]   request_tag  = '0;
    logic               is_disk      = 1'b0;
    logic [ADDR_W-1:0]  byte_address = '0;
    logic [PRI_W-1:0]   req_priority = '0;
    logic [TRACK_W-1:0] head_track   = '0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_data     = POL_FCFS;
    logic               done;
    logic [1:0]         status;
    logic [TAG_W-1:0]   out_tag;
    logic [ADDR_W-1:0]  out_address;
    logic               out_is_disk;
    logic [PEND_W-1:0]  pending;
    logic               moving_up;
    int                 failures;
    int                 outstanding;

    int                 gap_pct    = 25;
    int                 enq_sent   = 0;
    int                 deq_sent   = 0;
    int                 cfg_writes = 0;
    logic [TRACK_W-1:0] band_lo    = '0;

    disk_request_scheduler_top #(.QUEUE_DEPTH(DEPTH)) dut (.*);

    disk_request_scheduler_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (.*);

    always #4 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // Present one item, sometimes after a random idle burst, and hold it until taken.
    task automatic send_item(input logic c, input logic [TAG_W-1:0] tag, input logic disk,
                             input logic [ADDR_W-1:0] addr, input logic [PRI_W-1:0] pri,
                             input logic [TRACK_W-1:0] head);
        int gap;
        gap = 0;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= c;
        request_tag  <= tag;
        is_disk      <= disk;
        byte_address <= addr;
        req_priority <= pri;
        head_track   <= head;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (c == CMD_ENQUEUE)
            enq_sent++;
        else
            deq_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_policy(input policy_t p);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Mostly tracks inside a narrow window so seeks tie and cross the head.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [TRACK_W-1:0] trk;
        logic [8:0]         low;
        low = 9'($urandom());
        if ($urandom_range(0, 7) == 0)
            return $urandom();
        trk = TRACK_W'(band_lo + $urandom_range(0, BAND));
        return {trk, low};
    endfunction

    function automatic logic [TRACK_W-1:0] pick_head();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return TRACK_W'($urandom());
            default: return TRACK_W'(band_lo + $urandom_range(0, BAND));
        endcase
    endfunction

    initial
    begin
        int                enq_pct;
        int                disk_pct;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] addr;
        logic [PRI_W-1:0]  pri;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, then fill to the brim with field extremes
        send_item(CMD_DISPATCH, 8'h5A, 1'b1, 32'hFFFF_FFFF, 8'hFF, '1);
        for (int i = 0; i < DEPTH; i++)
        begin
            tag  = TAG_W'(i * 17);
            addr = ((100 + (i % 5) * 3) << TRACK_LSB) | i;
            if (i == 0)
                addr = '0;
            else if (i == 1)
                addr = '1;
            pri = PRI_W'(i * 7);
            if (i == 0)
                pri = '0;
            else if (i == 2 || i == 9)
                pri = '1;
            send_item(CMD_ENQUEUE, tag, (i % 4) != 3, addr, pri, TRACK_W'($urandom()));
        end
        send_item(CMD_ENQUEUE, 8'hAA, 1'b1, 32'h1234_5678, 8'h80, '0);

        // scan: top track, turn down, bottom track, turn up again
        write_policy(POL_SCAN);
        send_item(CMD_DISPATCH, 8'h00, 1'b0, '0, '0, '1);
        send_item(CMD_DISPATCH, 8'hFF, 1'b1, '1, '1, '1);
        send_item(CMD_DISPATCH, 8'h00, 1'b0, '0, '0, '0);
        send_item(CMD_DISPATCH, 8'hFF, 1'b1, '1, '1, '0);
        write_policy(POL_PRIORITY);
        send_item(CMD_DISPATCH, 8'h00, 1'b0, '0, '0, 23'd106);
        write_policy(POL_SSTF);
        send_item(CMD_DISPATCH, 8'h00, 1'b0, '0, '0, 23'd106);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_policy(policy_t'(p % 4));
            gap_pct  = (p == RANDOM_PHASES - 1) ? 0 : 25;
            enq_pct  = (p % 3 == 0) ? 75 : $urandom_range(35, 65);
            disk_pct = 10 + 30 * $urandom_range(0, 3);
            case ($urandom_range(0, 2))
                0:       band_lo = '0;
                1:       band_lo = TRACK_W'({TRACK_W{1'b1}} - BAND);
                default: band_lo = TRACK_W'($urandom_range(0, (1 << TRACK_W) - 1 - BAND));
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_item(($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DISPATCH,
                          TAG_W'($urandom()), $urandom_range(0, 99) < disk_pct,
                          pick_address(), PRI_W'($urandom()), pick_head());
        end

        wait_idle();
        repeat (40) @(posedge clk);
        $display("Covered %0d enqueues and %0d dispatches over %0d policy writes,",
                 enq_sent, deq_sent, cfg_writes);
        $display("with full and empty queues, scan turnarounds and bursty idle gaps.");
        if (failures == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
